[sv/blpg_pkg.sv]
// Shared types for the Bresenham line pixel generator.
package blpg_pkg;

  // Request kind carried in the input item's tuser bit.
  typedef enum logic {
    REQ_START = 1'b0,
    REQ_STEP  = 1'b1
  } req_kind_e;

  // Per-axis step control of the line being drawn.
  typedef struct packed {
    logic x_move;   // x changes when it is stepped
    logic x_neg;    // x steps downward
    logic y_move;
    logic y_neg;
    logic swapped;  // y is the major axis
  } blpg_dirs_t;

endpackage

[sv/blpg_line_setup.sv]
// Line setup: deltas, step directions, major axis, initial error term and pixel count.
module blpg_line_setup #(
  parameter int X_BITS = 10,
  parameter int Y_BITS = 9,
  parameter int D_BITS = 10
) (
  input  logic [X_BITS-1:0]    x_start_i,
  input  logic [Y_BITS-1:0]    y_start_i,
  input  logic [X_BITS-1:0]    x_end_i,
  input  logic [Y_BITS-1:0]    y_end_i,
  output logic [D_BITS-1:0]    major_o,
  output logic [D_BITS-1:0]    minor_o,
  output logic [D_BITS+1:0]    err_init_o,
  output logic [D_BITS:0]      count_o,
  output blpg_pkg::blpg_dirs_t dirs_o
);
  import blpg_pkg::*;

  logic [X_BITS-1:0] dx;
  logic [Y_BITS-1:0] dy;
  logic [D_BITS-1:0] dx_ext;
  logic [D_BITS-1:0] dy_ext;

  always_comb begin
    dirs_o.x_move = (x_end_i != x_start_i);
    dirs_o.x_neg  = (x_end_i < x_start_i);
    dirs_o.y_move = (y_end_i != y_start_i);
    dirs_o.y_neg  = (y_end_i < y_start_i);
    dx = dirs_o.x_neg ? (x_start_i - x_end_i) : (x_end_i - x_start_i);
    dy = dirs_o.y_neg ? (y_start_i - y_end_i) : (y_end_i - y_start_i);
    dx_ext = D_BITS'(dx);
    dy_ext = D_BITS'(dy);
    dirs_o.swapped = (dy_ext > dx_ext);
    major_o = dirs_o.swapped ? dy_ext : dx_ext;
    minor_o = dirs_o.swapped ? dx_ext : dy_ext;
    err_init_o = {1'b0, minor_o, 1'b0} - {2'b00, major_o};
    count_o = {1'b0, major_o} + (D_BITS+1)'(1);
  end

endmodule

[sv/bresenham_line_pixel_generator_unit.sv]
// Top level of the Bresenham line pixel generator with stream ports.
//
//  Channel  | Direction | Moves                       | Handshake
//  s_axis   | in        | line start or step request  | tvalid / tready
//  m_axis   | out       | one pixel per step          | tvalid / tready
//  cfg      | in        | frame buffer base address   | cfg_valid_i / cfg_ready_o
//
// One input item is taken per clock while the input side is not stalled; a step item's
// pixel sits in the output register on the following cycle. Start items and steps while
// idle give no pixel. The input side stalls only while a pixel is held in the output
// register and the sink is not ready. Reset leaves the block idle with a zero base address.
module bresenham_line_pixel_generator_unit #(
  parameter int ROW_SHIFT = 10,
  parameter int X_BITS    = 10,
  parameter int Y_BITS    = 9
) (
  input  logic clk_i,
  input  logic rst_ni,

  input  logic                    s_axis_tvalid,
  output logic                    s_axis_tready,
  // x_start, y_start, x_end, y_end, line_color, zero pad
  input  logic [((2*X_BITS+2*Y_BITS+8+7)/8)*8-1:0] s_axis_tdata,
  // req_type
  input  logic                    s_axis_tuser,

  output logic                    m_axis_tvalid,
  input  logic                    m_axis_tready,
  // pixel_x, pixel_y, pixel_address, pix_color, zero pad
  output logic [((X_BITS+Y_BITS+40+7)/8)*8-1:0] m_axis_tdata,
  output logic                    m_axis_tlast,

  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [31:0]             cfg_data_i
);
  import blpg_pkg::*;

  localparam int DBits   = (X_BITS > Y_BITS) ? X_BITS : Y_BITS;
  localparam int EBits   = DBits + 2;
  localparam int OutW    = ((X_BITS+Y_BITS+40+7)/8)*8;
  localparam int OutUsed = X_BITS + Y_BITS + 40;

  logic [31:0]       base_q;
  logic [X_BITS-1:0] cur_x_q, cur_x_d;
  logic [Y_BITS-1:0] cur_y_q, cur_y_d;
  logic [EBits-1:0]  err_q, err_d;
  logic [DBits-1:0]  major_q, major_d;
  logic [DBits-1:0]  minor_q, minor_d;
  blpg_dirs_t        dirs_q, dirs_d;
  logic [DBits:0]    left_q, left_d;
  logic [7:0]        color_q, color_d;
  logic              active_q, active_d;

  logic              out_valid_q, out_valid_d;
  logic [X_BITS-1:0] out_x_q;
  logic [Y_BITS-1:0] out_y_q;
  logic [31:0]       out_addr_q;
  logic [7:0]        out_color_q;
  logic              out_last_q;

  logic [X_BITS-1:0] in_xs, in_xe;
  logic [Y_BITS-1:0] in_ys, in_ye;
  logic [7:0]        in_color;
  logic [DBits-1:0]  su_major, su_minor;
  logic [EBits-1:0]  su_err;
  logic [DBits:0]    su_count;
  blpg_dirs_t        su_dirs;

  logic              accept;
  logic              emit;
  logic              err_ge;
  logic              x_step, y_step;
  logic [31:0]       pix_addr;

  assign in_xs    = s_axis_tdata[X_BITS-1:0];
  assign in_ys    = s_axis_tdata[X_BITS +: Y_BITS];
  assign in_xe    = s_axis_tdata[X_BITS+Y_BITS +: X_BITS];
  assign in_ye    = s_axis_tdata[2*X_BITS+Y_BITS +: Y_BITS];
  assign in_color = s_axis_tdata[2*X_BITS+2*Y_BITS +: 8];

  blpg_line_setup #(
    .X_BITS (X_BITS),
    .Y_BITS (Y_BITS),
    .D_BITS (DBits)
  ) u_setup (
    .x_start_i  (in_xs),
    .y_start_i  (in_ys),
    .x_end_i    (in_xe),
    .y_end_i    (in_ye),
    .major_o    (su_major),
    .minor_o    (su_minor),
    .err_init_o (su_err),
    .count_o    (su_count),
    .dirs_o     (su_dirs)
  );

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign emit          = accept && (s_axis_tuser == REQ_STEP) && active_q;
  assign cfg_ready_o   = 1'b1;

  assign pix_addr = base_q + (32'(cur_y_q) << ROW_SHIFT) + 32'(cur_x_q);

  always_comb begin
    cur_x_d  = cur_x_q;
    cur_y_d  = cur_y_q;
    err_d    = err_q;
    major_d  = major_q;
    minor_d  = minor_q;
    dirs_d   = dirs_q;
    left_d   = left_q;
    color_d  = color_q;
    active_d = active_q;
    // The minor axis steps only when the error term is not negative.
    err_ge = !err_q[EBits-1];
    x_step = dirs_q.x_move && (!dirs_q.swapped || err_ge);
    y_step = dirs_q.y_move && (dirs_q.swapped || err_ge);
    if (accept && (s_axis_tuser == REQ_START)) begin
      cur_x_d  = in_xs;
      cur_y_d  = in_ys;
      err_d    = su_err;
      major_d  = su_major;
      minor_d  = su_minor;
      dirs_d   = su_dirs;
      left_d   = su_count;
      color_d  = in_color;
      active_d = 1'b1;
    end else if (emit) begin
      if (x_step) begin
        cur_x_d = dirs_q.x_neg ? (cur_x_q - X_BITS'(1)) : (cur_x_q + X_BITS'(1));
      end
      if (y_step) begin
        cur_y_d = dirs_q.y_neg ? (cur_y_q - Y_BITS'(1)) : (cur_y_q + Y_BITS'(1));
      end
      err_d = err_q + {1'b0, minor_q, 1'b0}
            - (err_ge ? {1'b0, major_q, 1'b0} : EBits'(0));
      left_d   = left_q - (DBits+1)'(1);
      active_d = (left_q != (DBits+1)'(1));
    end
  end

  always_comb begin
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q      <= '0;
      cur_x_q     <= '0;
      cur_y_q     <= '0;
      err_q       <= '0;
      major_q     <= '0;
      minor_q     <= '0;
      dirs_q      <= '0;
      left_q      <= '0;
      color_q     <= '0;
      active_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        base_q <= cfg_data_i;
      end
      cur_x_q     <= cur_x_d;
      cur_y_q     <= cur_y_d;
      err_q       <= err_d;
      major_q     <= major_d;
      minor_q     <= minor_d;
      dirs_q      <= dirs_d;
      left_q      <= left_d;
      color_q     <= color_d;
      active_q    <= active_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_x_q     <= cur_x_q;
      out_y_q     <= cur_y_q;
      out_addr_q  <= pix_addr;
      out_color_q <= color_q;
      out_last_q  <= (left_q == (DBits+1)'(1));
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tdata  = {(OutW-OutUsed)'(0), out_color_q, out_addr_q, out_y_q, out_x_q};

endmodule

[tb/blpg_pixel_checker.sv]
// Pixel stream checker: predicts every pixel of the line generator and compares it.
module blpg_pixel_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  input  logic        s_tready_i,
  // x_start, y_start, x_end, y_end, line_color, zero pad
  input  logic [47:0] s_tdata_i,
  // req_type
  input  logic        s_tuser_i,
  input  logic        m_tvalid_i,
  input  logic        m_tready_i,
  // pixel_x, pixel_y, pixel_address, pix_color, zero pad
  input  logic [63:0] m_tdata_i,
  input  logic        m_tlast_i,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [31:0] cfg_data_i,
  output int          mismatch_count_o,
  output int          pixels_pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import blpg_pkg::*;

  localparam int ROW_SHIFT = 10;

  typedef struct packed {
    logic [9:0]  x;
    logic [8:0]  y;
    logic [31:0] addr;
    logic [7:0]  color;
    logic        last;
  } pixel_t;

  pixel_t      expected_pixels[$];
  int          mismatches;
  logic [31:0] frame_base;

  // Copy of the rasterizer state.
  logic [9:0]  pos_x;
  logic [8:0]  pos_y;
  int          error_acc;
  int          major_len;
  int          minor_len;
  blpg_dirs_t  dirs;
  int          pixels_left;
  logic [7:0]  line_color;
  logic        drawing;

  task automatic step_x();
    if (dirs.x_move) pos_x = dirs.x_neg ? pos_x - 10'd1 : pos_x + 10'd1;
  endtask

  task automatic step_y();
    if (dirs.y_move) pos_y = dirs.y_neg ? pos_y - 9'd1 : pos_y + 9'd1;
  endtask

  task automatic advance_line(req_kind_e kind, logic [47:0] d);
    logic [9:0] xs, xe;
    logic [8:0] ys, ye;
    int         dx, dy;
    pixel_t     px;
    xs = d[9:0];
    ys = d[18:10];
    xe = d[28:19];
    ye = d[37:29];
    if (kind == REQ_START) begin
      dx = (xe < xs) ? int'(xs) - int'(xe) : int'(xe) - int'(xs);
      dy = (ye < ys) ? int'(ys) - int'(ye) : int'(ye) - int'(ys);
      dirs.x_move  = (xe != xs);
      dirs.x_neg   = (xe < xs);
      dirs.y_move  = (ye != ys);
      dirs.y_neg   = (ye < ys);
      dirs.swapped = (dy > dx);
      major_len    = dirs.swapped ? dy : dx;
      minor_len    = dirs.swapped ? dx : dy;
      error_acc    = 2 * minor_len - major_len;
      pos_x        = xs;
      pos_y        = ys;
      line_color   = d[45:38];
      pixels_left  = major_len + 1;
      drawing      = 1'b1;
    end else if (drawing) begin
      px.x     = pos_x;
      px.y     = pos_y;
      px.addr  = frame_base + (32'(pos_y) << ROW_SHIFT) + 32'(pos_x);
      px.color = line_color;
      px.last  = (pixels_left == 1);
      expected_pixels.push_back(px);
      // The minor axis moves first when the error term has gone non-negative.
      if (error_acc >= 0) begin
        if (dirs.swapped) step_x();
        else step_y();
        error_acc -= 2 * major_len;
      end
      if (dirs.swapped) step_y();
      else step_x();
      error_acc += 2 * minor_len;
      pixels_left--;
      if (pixels_left == 0) drawing = 1'b0;
    end
  endtask

  task automatic check_pixel(logic [63:0] d, logic last);
    pixel_t want;
    if (expected_pixels.size() == 0) begin
      $error("unexpected pixel x=%0d y=%0d", d[9:0], d[18:10]);
      mismatches++;
    end else begin
      want = expected_pixels.pop_front();
      if (d[9:0] !== want.x) begin
        $error("pixel_x expected %0d, got %0d", want.x, d[9:0]);
        mismatches++;
      end
      if (d[18:10] !== want.y) begin
        $error("pixel_y expected %0d, got %0d", want.y, d[18:10]);
        mismatches++;
      end
      if (d[50:19] !== want.addr) begin
        $error("pixel_address expected %h, got %h", want.addr, d[50:19]);
        mismatches++;
      end
      if (d[58:51] !== want.color) begin
        $error("pix_color expected %h, got %h", want.color, d[58:51]);
        mismatches++;
      end
      if (last !== want.last) begin
        $error("last_pixel expected %0b, got %0b", want.last, last);
        mismatches++;
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_pixels.delete();
      mismatches       = 0;
      frame_base       = '0;
      pos_x            = '0;
      pos_y            = '0;
      error_acc        = 0;
      major_len        = 0;
      minor_len        = 0;
      dirs             = '0;
      pixels_left      = 0;
      line_color       = '0;
      drawing          = 1'b0;
      mismatch_count_o <= 0;
      pixels_pending_o <= 0;
    end else begin
      // A pixel leaving at this edge was predicted at an earlier edge.
      if (m_tvalid_i && m_tready_i) check_pixel(m_tdata_i, m_tlast_i);
      if (cfg_valid_i && cfg_ready_i) frame_base = cfg_data_i;
      if (s_tvalid_i && s_tready_i) advance_line(req_kind_e'(s_tuser_i), s_tdata_i);
      mismatch_count_o <= mismatches;
      pixels_pending_o <= expected_pixels.size();
    end
  end

endmodule

[tb/tb_bresenham_line_pixel_generator_unit.sv]
// Testbench top: drives line requests and base writes, and reports the verdict.
module tb_bresenham_line_pixel_generator_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import blpg_pkg::*;

  localparam int QUIET_LIMIT  = 2000;
  localparam int SETTLE_TICKS = 6;
  localparam int PHASE_ITEMS  = 200;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  // x_start, y_start, x_end, y_end, line_color, zero pad
  logic [47:0] s_axis_tdata;
  // req_type
  logic        s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  // pixel_x, pixel_y, pixel_address, pix_color, zero pad
  logic [63:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [31:0] cfg_data_i;

  int mismatch_count;
  int pixels_pending;
  int src_idle_pct;
  int sink_stall_pct;
  int items_sent;
  int quiet_cycles;

  bresenham_line_pixel_generator_unit u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  blpg_pixel_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .s_tvalid_i       (s_axis_tvalid),
    .s_tready_i       (s_axis_tready),
    .s_tdata_i        (s_axis_tdata),
    .s_tuser_i        (s_axis_tuser),
    .m_tvalid_i       (m_axis_tvalid),
    .m_tready_i       (m_axis_tready),
    .m_tdata_i        (m_axis_tdata),
    .m_tlast_i        (m_axis_tlast),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_i      (cfg_ready_o),
    .cfg_data_i       (cfg_data_i),
    .mismatch_count_o (mismatch_count),
    .pixels_pending_o (pixels_pending)
  );

  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic [47:0] pack_line(int xs, int ys, int xe, int ye, int color);
    return {2'b00, 8'(color), 9'(ye), 10'(xe), 9'(ys), 10'(xs)};
  endfunction

  // Endpoint near c, reflected back into range when it would fall outside.
  function automatic int near(int c, int hi, int span);
    int t;
    t = c + int'($urandom_range(2 * span)) - span;
    if (t < 0 || t > hi) t = 2 * c - t;
    return t;
  endfunction

  // Called at a rising edge; returns at the edge where the item is taken.
  task automatic send_item(req_kind_e kind, logic [47:0] d);
    if ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < src_idle_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= d;
    items_sent++;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  task automatic start_line(int xs, int ys, int xe, int ye, int color, output int len);
    int dx, dy;
    dx  = (xe > xs) ? xe - xs : xs - xe;
    dy  = (ye > ys) ? ye - ys : ys - ye;
    len = ((dx > dy) ? dx : dy) + 1;
    send_item(REQ_START, pack_line(xs, ys, xe, ye, color));
  endtask

  // Step requests carry random, ignored endpoint fields.
  task automatic step_line(int n);
    repeat (n) begin
      send_item(REQ_STEP, pack_line($urandom_range(1023), $urandom_range(511),
                                    $urandom_range(1023), $urandom_range(511),
                                    $urandom_range(255)));
    end
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pixels_pending != 0) @(posedge clk_i);
    // A trailing step while idle may still be in flight.
    repeat (SETTLE_TICKS) @(posedge clk_i);
  endtask

  task automatic write_base(logic [31:0] base);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= base;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic run_lines(int target);
    int r, xs, ys, xe, ye, len, steps;
    while (items_sent < target) begin
      r  = $urandom_range(99);
      xs = $urandom_range(1023);
      ys = $urandom_range(511);
      if (r < 80) begin
        xe = near(xs, 1023, 12);
        ye = near(ys, 511, 12);
        if (r < 6) ye = near(ys, 511, 0);
        if (r >= 6 && r < 12) begin
          xe = xs;
        end
      end else if (r < 97) begin
        xe = $urandom_range(1023);
        ye = $urandom_range(511);
      end else begin
        xe = near(xs, 1023, 150);
        ye = near(ys, 511, 150);
      end
      start_line(xs, ys, xe, ye, $urandom_range(255), len);
      if (r >= 80 && r < 97) begin
        steps = $urandom_range(16);
      end else if ($urandom_range(9) == 0) begin
        steps = $urandom_range(len);
      end else begin
        steps = len + (($urandom_range(7) == 0) ? $urandom_range(1, 3) : 0);
      end
      step_line(steps);
    end
  endtask

  initial begin
    logic [31:0] bases[8];
    int          len;
    bases = '{32'hFFFF_FFFF, 32'h0000_0000, $urandom, 32'hFFF8_0000,
              $urandom, 32'h8000_0000, $urandom, 32'hFFFF_FC00};
    rst_ni         = 1'b0;
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = '0;
    s_axis_tuser   = REQ_START;
    cfg_valid_i    = 1'b0;
    cfg_data_i     = '0;
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    items_sent     = 0;
    quiet_cycles   = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part, with the reset base of zero.
    step_line(1);
    start_line(0, 0, 0, 0, 8'h00, len);
    step_line(len + 1);
    start_line(1023, 511, 0, 0, 8'hFF, len);
    step_line(3);
    start_line(0, 511, 1023, 0, 8'hA5, len);
    step_line(3);
    start_line(10, 20, 12, 26, 8'h3C, len);
    step_line(len);

    for (int p = 0; p < 8; p++) begin
      write_base(bases[p]);
      case (p % 4)
        0: begin
          src_idle_pct   = 0;
          sink_stall_pct = 0;
        end
        1: begin
          src_idle_pct   = 57;
          sink_stall_pct = 0;
        end
        2: begin
          src_idle_pct   = 0;
          sink_stall_pct = 57;
        end
        default: begin
          src_idle_pct   = 25;
          sink_stall_pct = 25;
        end
      endcase
      run_lines(items_sent + PHASE_ITEMS);
    end

    drain();
    if (mismatch_count == 0 && pixels_pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

[bresenham_line_pixel_generator_unit.f]
sv/blpg_pkg.sv
sv/blpg_line_setup.sv
sv/bresenham_line_pixel_generator_unit.sv
tb/blpg_pixel_checker.sv
tb/tb_bresenham_line_pixel_generator_unit.sv
